### rtl/core/slab_buffer_manager_assert.svh
// Assertion macros used by the slab buffer manager datapath.
// Both expect clk and rst_n in scope.
`ifndef SLAB_BUFFER_MANAGER_ASSERT_SVH
`define SLAB_BUFFER_MANAGER_ASSERT_SVH

// Same-cycle implication.
`define SBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sbm_pkg.sv
package sbm_pkg;

  localparam int SLAB_W     = 8;
  localparam int SLOT_W     = 16;
  localparam int STS_W      = 2;
  localparam int LIVE_W     = 9;
  localparam int CAP_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STS_W-1:0] STS_OK           = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_ID        = 2'd1;
  localparam logic [STS_W-1:0] STS_OVER_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_SLAB = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REUSE_CAP      = 1'b1;

  localparam logic [SLOT_W-1:0] SLOTS_RESET = 16'd10000;
  localparam logic [CAP_W-1:0]  CAP_RESET   = 9'd100;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } sbm_state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] cursor;
    logic [SLOT_W-1:0] released;
  } slab_ent_t;

  typedef struct packed {
    logic clr_en;
    logic in_ready;
    logic fire;
  } sbm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } sbm_stat_t;

endpackage

### rtl/core/sbm_channels.sv
interface sbm_in_if import sbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [SLAB_W-1:0] slab_id;

  modport source (output valid, command, slab_id, input ready);
  modport sink   (input valid, command, slab_id, output ready);
endinterface

interface sbm_out_if import sbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic [SLAB_W-1:0] granted_slab;
  logic [SLOT_W-1:0] granted_slot;
  logic              slab_retired;
  logic [LIVE_W-1:0] live_slabs;

  modport source (output valid, status, granted_slab, granted_slot, slab_retired, live_slabs,
                  input ready);
  modport sink   (input valid, status, granted_slab, granted_slot, slab_retired, live_slabs,
                  output ready);
endinterface

interface sbm_cfg_if import sbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/sbm_ctrl.sv
module sbm_ctrl import sbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  sbm_stat_t stat,
  output sbm_cmd_t  cmd
);

  sbm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.clr_en   = 1'b0;
    cmd.in_ready = 1'b0;
    cmd.fire     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat.out_busy) begin
          cmd.fire  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

### rtl/core/sbm_datapath.sv
module sbm_datapath import sbm_pkg::*; #(
  parameter int MAX_SLABS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbm_cmd_t              cmd,
  output sbm_stat_t             stat,
  input  logic                  in_valid,
  input  logic                  in_command,
  input  logic [SLAB_W-1:0]     in_slab_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STS_W-1:0]      out_status,
  output logic [SLAB_W-1:0]     out_granted_slab,
  output logic [SLOT_W-1:0]     out_granted_slot,
  output logic                  out_slab_retired,
  output logic [LIVE_W-1:0]     out_live_slabs,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "slab_buffer_manager_assert.svh"

  localparam int IDW  = $clog2(MAX_SLABS);
  localparam int CW   = $clog2(MAX_SLABS + 1);
  localparam int IDX  = (IDW > SLAB_W) ? IDW : SLAB_W;
  localparam int CMPW = ((CW > CAP_W) ? CW : CAP_W) + 1;

  // storage
  slab_ent_t      tbl_mem  [MAX_SLABS];
  logic [IDW-1:0] stk_mem  [MAX_SLABS];
  logic [IDW-1:0] pool_mem [MAX_SLABS];

  // config
  logic [SLOT_W-1:0] spp_r;
  logic [CAP_W-1:0]  cap_r;

  // control state
  logic [IDW-1:0] clr_idx_r;
  logic [IDW-1:0] cur_r, cur_nxt;
  logic [CW-1:0]  reuse_cnt_r, reuse_cnt_nxt;
  logic [CW-1:0]  unused_cnt_r, unused_cnt_nxt;
  logic [CW-1:0]  live_r, live_nxt;
  logic           out_valid_r;

  // request latch and registered reads
  logic           cmd_r;
  logic [IDW-1:0] id_r;
  logic           in_range_r;
  slab_ent_t      ent_r;
  logic [IDW-1:0] stk_top_r;
  logic [IDW-1:0] pool_top_r;

  // output payload
  logic [STS_W-1:0]  sts_r,     sts_nxt;
  logic [SLAB_W-1:0] gslab_r,   gslab_nxt;
  logic [SLOT_W-1:0] gslot_r,   gslot_nxt;
  logic              retired_r, retired_nxt;
  logic [LIVE_W-1:0] live_o_r;

  // write controls
  logic           tbl_we;
  logic [IDW-1:0] tbl_wa;
  slab_ent_t      tbl_wd;
  logic           stk_we;
  logic           pool_we;

  logic              accept;
  logic              in_range;
  logic [IDW-1:0]    rd_addr;
  logic [SLOT_W-1:0] limit;
  logic              full;
  logic [SLOT_W-1:0] rel_inc;

  assign accept   = cmd.in_ready & in_valid;
  assign in_range = int'(in_slab_id) < MAX_SLABS;
  assign rd_addr  = (in_command == CMD_RELEASE) ? IDW'(IDX'(in_slab_id)) : cur_r;
  assign limit    = (spp_r == '0) ? SLOT_W'(1) : spp_r;
  assign full     = ent_r.cursor >= limit;
  assign rel_inc  = ent_r.released + SLOT_W'(1);

  assign stat.clr_last = clr_idx_r == IDW'(MAX_SLABS - 1);
  assign stat.out_busy = out_valid_r & ~out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r <= SLOTS_RESET;
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SLOTS_PER_SLAB: spp_r <= cfg_data;
        CFG_REUSE_CAP:      cap_r <= cfg_data[CAP_W-1:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    cur_nxt        = cur_r;
    reuse_cnt_nxt  = reuse_cnt_r;
    unused_cnt_nxt = unused_cnt_r;
    live_nxt       = live_r;
    sts_nxt        = STS_OK;
    gslab_nxt      = '0;
    gslot_nxt      = '0;
    retired_nxt    = 1'b0;
    tbl_we         = 1'b0;
    tbl_wa         = cur_r;
    tbl_wd         = ent_r;
    stk_we         = 1'b0;
    pool_we        = 1'b0;
    if (cmd_r == CMD_ALLOC) begin
      tbl_we        = 1'b1;
      tbl_wd.cursor   = SLOT_W'(1);
      tbl_wd.released = '0;
      if (!full) begin
        tbl_wd.cursor   = ent_r.cursor + SLOT_W'(1);
        tbl_wd.released = ent_r.released;
        gslot_nxt       = ent_r.cursor;
      end else if (ent_r.released == ent_r.cursor) begin
        tbl_wa = cur_r;
      end else if (reuse_cnt_r != '0) begin
        reuse_cnt_nxt = reuse_cnt_r - CW'(1);
        cur_nxt       = stk_top_r;
        tbl_wa        = stk_top_r;
        live_nxt      = live_r + CW'(1);
      end else if (unused_cnt_r != '0) begin
        unused_cnt_nxt = unused_cnt_r - CW'(1);
        cur_nxt        = pool_top_r;
        tbl_wa         = pool_top_r;
        live_nxt       = live_r + CW'(1);
      end else begin
        tbl_we  = 1'b0;
        sts_nxt = STS_NO_ID;
      end
      if (sts_nxt == STS_OK) gslab_nxt = SLAB_W'(IDX'(cur_nxt));
    end else begin
      if (!in_range_r || ent_r.released >= ent_r.cursor) begin
        sts_nxt = STS_OVER_RELEASE;
      end else begin
        tbl_we          = 1'b1;
        tbl_wa          = id_r;
        tbl_wd.released = rel_inc;
        if (id_r != cur_r && rel_inc == ent_r.cursor) begin
          if (live_r != '0) live_nxt = live_r - CW'(1);
          if (CMPW'(reuse_cnt_r) + CMPW'(1) > CMPW'(cap_r) ||
              reuse_cnt_r >= CW'(MAX_SLABS)) begin
            if (unused_cnt_r < CW'(MAX_SLABS)) begin
              pool_we        = 1'b1;
              unused_cnt_nxt = unused_cnt_r + CW'(1);
            end
            retired_nxt = 1'b1;
          end else begin
            stk_we        = 1'b1;
            reuse_cnt_nxt = reuse_cnt_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r    <= '0;
      cur_r        <= '0;
      reuse_cnt_r  <= '0;
      unused_cnt_r <= CW'(MAX_SLABS - 1);
      live_r       <= CW'(1);
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_idx_r <= clr_idx_r + IDW'(1);
      if (cmd.fire) begin
        cur_r        <= cur_nxt;
        reuse_cnt_r  <= reuse_cnt_nxt;
        unused_cnt_r <= unused_cnt_nxt;
        live_r       <= live_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_command;
      id_r       <= IDW'(IDX'(in_slab_id));
      in_range_r <= in_range;
      ent_r      <= tbl_mem[rd_addr];
      stk_top_r  <= stk_mem[IDW'(reuse_cnt_r - CW'(1))];
      pool_top_r <= pool_mem[IDW'(unused_cnt_r - CW'(1))];
    end
    if (cmd.fire) begin
      sts_r     <= sts_nxt;
      gslab_r   <= gslab_nxt;
      gslot_r   <= gslot_nxt;
      retired_r <= retired_nxt;
      live_o_r  <= LIVE_W'(live_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      tbl_mem[clr_idx_r] <= '0;
    end else if (cmd.fire && tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && stk_we) begin
      stk_mem[IDW'(reuse_cnt_r)] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      pool_mem[clr_idx_r] <= IDW'(MAX_SLABS - 1) - clr_idx_r;
    end else if (cmd.fire && pool_we) begin
      pool_mem[IDW'(unused_cnt_r)] <= id_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = sts_r;
  assign out_granted_slab = gslab_r;
  assign out_granted_slot = gslot_r;
  assign out_slab_retired = retired_r;
  assign out_live_slabs   = live_o_r;

  `SBM_ASSERT_NOW(a_id_conserved, 1'b1,
    (CW+2)'(live_r) + (CW+2)'(reuse_cnt_r) + (CW+2)'(unused_cnt_r) == (CW+2)'(MAX_SLABS),
    "slab ids lost or duplicated")
  `SBM_ASSERT_NOW(a_fire_out_free, cmd.fire, !out_valid_r || out_ready,
    "result overwritten before taken")
  `SBM_ASSERT_NOW(a_grant_in_limit, cmd.fire && cmd_r == CMD_ALLOC && sts_nxt == STS_OK,
    gslot_nxt < limit, "granted slot beyond slab size")
  `SBM_ASSERT_NOW(a_no_accept_in_clear, cmd.clr_en, !accept,
    "request taken during table clear")
  `SBM_ASSERT_NEXT(a_fire_shows_result, cmd.fire, out_valid_r,
    "result not presented after update")

endmodule

### rtl/core/slab_buffer_manager.sv
// Slab buffer manager: hands out slots from a current slab, counts released
// slots back per slab, recycles fully released slabs through a bounded reuse
// stack and retires the rest to an unused id pool. Each request is handled as
// a slab table read, then an update with stack or pool access that waits
// for the result register to drain; the next request is accepted while
// a result is still waiting. After reset a clearing pass over every entry
// initializes the slab table and id pool, during which no request is taken;
// configuration writes are accepted at any time and are meant for idle.
module slab_buffer_manager import sbm_pkg::*; #(
  parameter int MAX_SLABS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  sbm_in_if.sink    in_ch,
  sbm_out_if.source out_ch,
  sbm_cfg_if.sink   cfg_ch
);

  sbm_cmd_t  cmd;
  sbm_stat_t stat;

  assign in_ch.ready  = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;

  sbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbm_datapath #(
    .MAX_SLABS (MAX_SLABS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_valid         (in_ch.valid),
    .in_command       (in_ch.command),
    .in_slab_id       (in_ch.slab_id),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_granted_slab (out_ch.granted_slab),
    .out_granted_slot (out_ch.granted_slot),
    .out_slab_retired (out_ch.slab_retired),
    .out_live_slabs   (out_ch.live_slabs),
    .cfg_valid        (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data)
  );

endmodule

### sim/slab_buffer_manager_tb.sv
`timescale 1ns / 100ps

module slab_buffer_manager_tb;
  import sbm_pkg::*;

  localparam int NUM_SLABS   = 256;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [SLAB_W-1:0] slab;
    logic [SLOT_W-1:0] slot;
    logic              retired;
    logic [LIVE_W-1:0] live;
  } slab_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sbm_in_if  in_ch();
  sbm_out_if out_ch();
  sbm_cfg_if cfg_ch();

  slab_buffer_manager #(.MAX_SLABS(NUM_SLABS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the slab table and id stores
  int fill_cnt [NUM_SLABS];
  int back_cnt [NUM_SLABS];
  int active_slab;
  int reuse_ids [NUM_SLABS];
  int reuse_depth;
  int free_ids [NUM_SLABS];
  int free_depth;
  int in_use;
  int cfg_slots;
  int cfg_cap;

  slab_result_t pending_replies[$];
  slab_result_t want;
  slab_result_t last_pred;

  int errors        = 0;
  int cycle_count   = 0;
  int send_idle_pct = 20;
  int recv_stall_pct = 20;
  int hold_request  = 0;
  int hold_left     = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          errors++;
        end
        if (out_ch.granted_slab !== want.slab) begin
          $error("granted_slab: expected %0d, got %0d", want.slab, out_ch.granted_slab);
          errors++;
        end
        if (out_ch.granted_slot !== want.slot) begin
          $error("granted_slot: expected %0d, got %0d", want.slot, out_ch.granted_slot);
          errors++;
        end
        if (out_ch.slab_retired !== want.retired) begin
          $error("slab_retired: expected %0d, got %0d", want.retired, out_ch.slab_retired);
          errors++;
        end
        if (out_ch.live_slabs !== want.live) begin
          $error("live_slabs: expected %0d, got %0d", want.live, out_ch.live_slabs);
          errors++;
        end
      end
    end
  end

  function automatic void reset_shadow();
    for (int i = 0; i < NUM_SLABS; i++) begin
      fill_cnt[i] = 0;
      back_cnt[i] = 0;
      reuse_ids[i] = 0;
      free_ids[i] = 0;
    end
    for (int i = 0; i + 1 < NUM_SLABS; i++)
      free_ids[i] = NUM_SLABS - 1 - i;
    free_depth  = NUM_SLABS - 1;
    reuse_depth = 0;
    active_slab = 0;
    in_use      = 1;
    cfg_slots   = int'(SLOTS_RESET);
    cfg_cap     = int'(CAP_RESET);
  endfunction

  function automatic slab_result_t account_request(logic cmd, logic [SLAB_W-1:0] id);
    slab_result_t r;
    int limit;
    int cur;
    bit ok;
    r = '0;
    limit = (cfg_slots == 0) ? 1 : cfg_slots;
    if (cmd == CMD_ALLOC) begin
      cur = active_slab;
      ok = 1'b1;
      if (fill_cnt[cur] >= limit) begin
        if (back_cnt[cur] == fill_cnt[cur]) begin
          fill_cnt[cur] = 0;
          back_cnt[cur] = 0;
        end else if (reuse_depth > 0) begin
          reuse_depth--;
          cur = reuse_ids[reuse_depth] % NUM_SLABS;
          fill_cnt[cur] = 0;
          back_cnt[cur] = 0;
          in_use++;
        end else if (free_depth > 0) begin
          free_depth--;
          cur = free_ids[free_depth] % NUM_SLABS;
          fill_cnt[cur] = 0;
          back_cnt[cur] = 0;
          in_use++;
        end else begin
          ok = 1'b0;
          r.status = STS_NO_ID;
        end
      end
      if (ok) begin
        active_slab = cur;
        r.slab = cur[SLAB_W-1:0];
        r.slot = fill_cnt[cur][SLOT_W-1:0];
        fill_cnt[cur]++;
      end
    end else begin
      if (back_cnt[id] >= fill_cnt[id]) begin
        r.status = STS_OVER_RELEASE;
      end else begin
        back_cnt[id]++;
        if (int'(id) != active_slab && back_cnt[id] == fill_cnt[id]) begin
          if (in_use > 0)
            in_use--;
          if (reuse_depth + 1 > cfg_cap || reuse_depth >= NUM_SLABS) begin
            if (free_depth < NUM_SLABS) begin
              free_ids[free_depth] = int'(id);
              free_depth++;
            end
            r.retired = 1'b1;
          end else begin
            reuse_ids[reuse_depth] = int'(id);
            reuse_depth++;
          end
        end
      end
    end
    r.live = in_use[LIVE_W-1:0];
    return r;
  endfunction

  function automatic logic [SLAB_W-1:0] pick_owed_slab();
    int owed[$];
    for (int i = 0; i < NUM_SLABS; i++)
      if (back_cnt[i] < fill_cnt[i])
        owed.push_back(i);
    if (owed.size() == 0)
      return SLAB_W'($urandom_range(0, NUM_SLABS - 1));
    return SLAB_W'(owed[$urandom_range(0, owed.size() - 1)]);
  endfunction

  task automatic send_beat(input logic cmd, input logic [SLAB_W-1:0] id);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.command = cmd;
    in_ch.slab_id = id;
    do @(posedge clk); while (!in_ch.ready);
    last_pred = account_request(cmd, id);
    pending_replies.push_back(last_pred);
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_replies.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_SLOTS_PER_SLAB)
      cfg_slots = value & 'hFFFF;
    else
      cfg_cap = value & 'h1FF;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic test_directed();
    // reset config first: 10000 slots, cap 100
    send_beat(CMD_ALLOC, 8'hAA);
    send_beat(CMD_ALLOC, 8'h55);
    send_beat(CMD_RELEASE, 8'd0);
    send_beat(CMD_RELEASE, 8'd0);
    send_beat(CMD_RELEASE, 8'd0);
    send_beat(CMD_RELEASE, 8'hFF);
    quiesce();
    // zero slots behaves as one, cap of one
    write_reg(CFG_SLOTS_PER_SLAB, 0);
    write_reg(CFG_REUSE_CAP, 1);
    send_beat(CMD_ALLOC, 8'hFF);
    send_beat(CMD_ALLOC, 8'h00);
    send_beat(CMD_ALLOC, 8'h0F);
    send_beat(CMD_RELEASE, 8'd0);
    send_beat(CMD_RELEASE, 8'd1);
    send_beat(CMD_RELEASE, 8'd1);
    send_beat(CMD_RELEASE, 8'd2);
    send_beat(CMD_ALLOC, 8'hF0);
    send_beat(CMD_ALLOC, 8'h01);
    send_beat(CMD_ALLOC, 8'h80);
    send_beat(CMD_RELEASE, 8'd255);
    send_beat(CMD_RELEASE, 8'd128);
    quiesce();
  endtask

  task automatic test_out_of_ids();
    int no_id;
    int guard;
    write_reg(CFG_SLOTS_PER_SLAB, 1);
    write_reg(CFG_REUSE_CAP, 0);
    no_id = 0;
    guard = 0;
    while (no_id < 3 && guard < 600) begin
      send_beat(CMD_ALLOC, SLAB_W'($urandom_range(0, 255)));
      if (last_pred.status == STS_NO_ID)
        no_id++;
      guard++;
    end
    // cap zero: every drained slab is retired
    for (int i = 0; i < NUM_SLABS / 2; i++)
      while (back_cnt[i] < fill_cnt[i])
        send_beat(CMD_RELEASE, SLAB_W'(i));
    quiesce();
    write_reg(CFG_REUSE_CAP, 256);
    for (int i = NUM_SLABS / 2; i < NUM_SLABS; i++)
      while (back_cnt[i] < fill_cnt[i])
        send_beat(CMD_RELEASE, SLAB_W'(i));
    quiesce();
    // cap lowered below a deep stack
    write_reg(CFG_REUSE_CAP, 2);
    for (int i = 0; i < 12; i++)
      send_beat(CMD_ALLOC, SLAB_W'($urandom_range(0, 255)));
    for (int i = 0; i < 12; i++)
      send_beat(CMD_RELEASE, pick_owed_slab());
    quiesce();
  endtask

  task automatic new_random_config();
    int slots;
    int cap;
    case ($urandom_range(0, 9))
      0: slots = 0;
      1: slots = 1;
      2: slots = 65535;
      default: slots = $urandom_range(2, 6);
    endcase
    case ($urandom_range(0, 7))
      0: cap = 0;
      1: cap = 256;
      default: cap = $urandom_range(1, 6);
    endcase
    write_reg(CFG_SLOTS_PER_SLAB, slots);
    write_reg(CFG_REUSE_CAP, cap);
  endtask

  task automatic run_random(input int beats, input int idle_pct, input int stall_pct,
                            input bit squeeze);
    int alloc_pct;
    int seg;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    seg = 0;
    alloc_pct = 50;
    for (int i = 0; i < beats; i++) begin
      if (seg == 0) begin
        quiesce();
        new_random_config();
        seg = $urandom_range(60, 120);
        alloc_pct = $urandom_range(40, 65);
      end
      seg--;
      if ($urandom_range(0, 99) < 8)
        send_beat(1'($urandom_range(0, 1)), SLAB_W'($urandom_range(0, 255)));
      else if ($urandom_range(0, 99) < alloc_pct)
        send_beat(CMD_ALLOC, SLAB_W'($urandom_range(0, 255)));
      else
        send_beat(CMD_RELEASE, pick_owed_slab());
      if (squeeze && i == 40)
        hold_request = 500;
    end
    quiesce();
  endtask

  task automatic test_random_busy_sender();
    run_random(400, 37, 68, 1'b1);
  endtask

  task automatic test_random_busy_receiver();
    run_random(400, 68, 37, 1'b0);
  endtask

  task automatic test_random_full_rate();
    run_random(400, 0, 0, 1'b1);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_ALLOC;
    in_ch.slab_id = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_SLOTS_PER_SLAB;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    reset_shadow();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_out_of_ids();
    test_random_busy_sender();
    test_random_busy_receiver();
    test_random_full_rate();

    repeat (20) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
